>>> rtl/lfp_pkg.sv
// Shared types and constants for the lambda frame parser.
`timescale 1ns / 1ps

package lfp_pkg;

    localparam int unsigned FIELD_COUNT = 4;
    localparam int unsigned FC_W        = 3;
    localparam int unsigned VALUE_W     = 16;
    localparam int unsigned STATUS_W    = 4;

    localparam logic [FC_W-1:0] FC_LAST = FC_W'(FIELD_COUNT - 1);
    localparam logic [FC_W-1:0] FC_FULL = FC_W'(FIELD_COUNT);

    localparam logic [7:0] CH_NUL   = 8'd0;
    localparam logic [7:0] CH_TAB   = 8'd9;
    localparam logic [7:0] CH_CR    = 8'd13;
    localparam logic [7:0] CH_SPACE = 8'd32;
    localparam logic [7:0] CH_PLUS  = 8'd43;
    localparam logic [7:0] CH_MINUS = 8'd45;
    localparam logic [7:0] CH_ZERO  = 8'd48;
    localparam logic [7:0] CH_NINE  = 8'd57;
    localparam logic [7:0] CH_SEMI  = 8'd59;

    localparam logic [1:0] PH_START  = 2'd0;
    localparam logic [1:0] PH_SPACE  = 2'd1;
    localparam logic [1:0] PH_NUMBER = 2'd2;
    localparam logic [1:0] PH_DONE   = 2'd3;

    localparam logic [VALUE_W-1:0] PROBE_NONE = 16'd127;

    localparam logic [STATUS_W-1:0] ST_OK        = 4'd0;
    localparam logic [STATUS_W-1:0] ST_CHECKSUM  = 4'd1;
    localparam logic [STATUS_W-1:0] ST_NO_PROBE  = 4'd2;
    localparam logic [STATUS_W-1:0] ST_CJ        = 4'd3;
    localparam logic [STATUS_W-1:0] ST_VLOW      = 4'd4;
    localparam logic [STATUS_W-1:0] ST_VHIGH     = 4'd5;
    localparam logic [STATUS_W-1:0] ST_CJ_COMM   = 4'd6;
    localparam logic [STATUS_W-1:0] ST_HEAT_OFF  = 4'd7;
    localparam logic [STATUS_W-1:0] ST_HEATING   = 4'd8;
    localparam logic [STATUS_W-1:0] ST_TEMP_HIGH = 4'd9;

    typedef struct packed {
        logic               have_last;
        logic [VALUE_W-1:0] lambda_field;
        logic [VALUE_W-1:0] status_field;
        logic [VALUE_W-1:0] probe_field;
        logic [VALUE_W-1:0] check;
    } lfp_frame_t;

endpackage

>>> rtl/lfp_if.sv
// Character and result channel interfaces of the lambda frame parser.
`timescale 1ns / 1ps

interface lfp_char_if;
    logic       valid;
    logic       ready;
    logic [7:0] char_in;

    modport source (output valid, output char_in, input ready);
    modport sink   (input valid, input char_in, output ready);
endinterface

interface lfp_result_if;
    logic        valid;
    logic        ready;
    logic [15:0] lambda_value;
    logic [3:0]  status;

    modport source (output valid, output lambda_value, output status, input ready);
    modport sink   (input valid, input lambda_value, input status, output ready);
endinterface

>>> rtl/lfp_field_parser.sv
// Field parser: holds the per-frame state and advances it one character at a time.
`timescale 1ns / 1ps

module lfp_field_parser (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              step,
    input  logic [7:0]        char_in,
    output lfp_pkg::lfp_frame_t frame,
    output logic [2:0]        field_count
);
    import lfp_pkg::*;

    logic [FC_W-1:0]    fc_reg, fc_next;
    logic [1:0]         phase_reg, phase_next;
    logic               neg_reg, neg_next;
    logic [VALUE_W-1:0] acc_reg, acc_next;
    logic [VALUE_W-1:0] lambda_reg, lambda_next;
    logic [VALUE_W-1:0] status_reg, status_next;
    logic [VALUE_W-1:0] probe_reg, probe_next;

    logic [VALUE_W-1:0] value;
    logic [VALUE_W-1:0] digit;
    logic               is_digit;
    logic               is_space;
    logic               full;

    assign value    = neg_reg ? (VALUE_W'(0) - acc_reg) : acc_reg;
    assign digit    = {12'd0, char_in[3:0]};
    assign is_digit = (char_in >= CH_ZERO) && (char_in <= CH_NINE);
    assign is_space = (char_in == CH_SPACE) || ((char_in >= CH_TAB) && (char_in <= CH_CR));
    assign full     = (fc_reg >= FC_FULL);

    always_comb
    begin
        frame.lambda_field = lambda_reg;
        frame.status_field = status_reg;
        frame.probe_field  = probe_reg;
        frame.check        = full ? acc_reg : value;
        frame.have_last    = full || ((fc_reg == FC_LAST) && (phase_reg != PH_START));
    end

    assign field_count = fc_reg;

    always_comb
    begin
        fc_next     = fc_reg;
        phase_next  = phase_reg;
        neg_next    = neg_reg;
        acc_next    = acc_reg;
        lambda_next = lambda_reg;
        status_next = status_reg;
        probe_next  = probe_reg;
        if (char_in == CH_NUL)
        begin
            fc_next     = '0;
            phase_next  = PH_START;
            neg_next    = 1'b0;
            acc_next    = '0;
            lambda_next = '0;
            status_next = '0;
            probe_next  = '0;
        end
        else if (!full)
        begin
            if (char_in == CH_SEMI)
            begin
                if (fc_reg == 3'd0)
                    lambda_next = value;
                if (fc_reg == 3'd1)
                    status_next = value;
                if (fc_reg == 3'd2)
                    probe_next = value;
                fc_next    = fc_reg + 3'd1;
                phase_next = PH_START;
                neg_next   = 1'b0;
                acc_next   = (fc_reg == FC_LAST) ? value : '0;
            end
            else if (phase_reg == PH_START || phase_reg == PH_SPACE)
            begin
                if (is_space)
                    phase_next = PH_SPACE;
                else if (char_in == CH_PLUS || char_in == CH_MINUS)
                begin
                    neg_next   = (char_in == CH_MINUS);
                    phase_next = PH_NUMBER;
                end
                else if (is_digit)
                begin
                    acc_next   = digit;
                    phase_next = PH_NUMBER;
                end
                else
                    phase_next = PH_DONE;
            end
            else if (phase_reg == PH_NUMBER)
            begin
                if (is_digit)
                    acc_next = (acc_reg << 3) + (acc_reg << 1) + digit;
                else
                    phase_next = PH_DONE;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fc_reg     <= '0;
            phase_reg  <= PH_START;
            neg_reg    <= 1'b0;
            acc_reg    <= '0;
            lambda_reg <= '0;
            status_reg <= '0;
            probe_reg  <= '0;
        end
        else if (step)
        begin
            fc_reg     <= fc_next;
            phase_reg  <= phase_next;
            neg_reg    <= neg_next;
            acc_reg    <= acc_next;
            lambda_reg <= lambda_next;
            status_reg <= status_next;
            probe_reg  <= probe_next;
        end
    end

endmodule

>>> rtl/lfp_status_decode.sv
// Status decoder: checksum test and fixed-priority status word decode.
`timescale 1ns / 1ps

module lfp_status_decode (
    input  lfp_pkg::lfp_frame_t frame,
    output logic [15:0]         lambda_value,
    output logic [3:0]          status
);
    import lfp_pkg::*;

    logic [VALUE_W-1:0] sum;
    logic [VALUE_W-1:0] s;

    assign sum = frame.lambda_field + frame.status_field + frame.probe_field;
    assign s   = frame.status_field;

    always_comb
    begin
        if (!frame.have_last || (~sum != frame.check))
            status = ST_CHECKSUM;
        else if (frame.probe_field == PROBE_NONE)
            status = ST_NO_PROBE;
        else if (s[0])
            status = ST_CJ;
        else if (s[2])
            status = ST_VLOW;
        else if (s[3])
            status = ST_VHIGH;
        else if (s[4])
            status = ST_CJ_COMM;
        else if (!s[5])
            status = s[7] ? ST_HEATING : ST_HEAT_OFF;
        else if (s[1])
            status = ST_TEMP_HIGH;
        else
            status = ST_OK;
    end

    assign lambda_value = (status == ST_OK) ? frame.lambda_field : '0;

endmodule

>>> rtl/lambda_frame_parser_core.sv
// Lambda frame parser top level: input register, field parser, status decode, result register.
// A NUL word is held in the input register; its decoded result is loaded into the result register once that is free.
// Throughput: one character word per cycle; a NUL word waits in the input register only
// while the result register still holds an untaken result, other words keep flowing.
// Reset: rst_n clears the parser state and both valid flags; the next frame starts fresh.
`timescale 1ns / 1ps

module lambda_frame_parser_core (
    input  logic                clk,
    input  logic                rst_n,
    lfp_char_if.sink            frame,
    lfp_result_if.source        result
);
    import lfp_pkg::*;

    logic               in_valid_reg;
    logic [7:0]         in_char_reg;
    logic               out_valid_reg;
    logic [VALUE_W-1:0] out_lambda_reg;
    logic [STATUS_W-1:0] out_status_reg;

    logic               is_nul;
    logic               out_free;
    logic               step;
    logic               emit;
    lfp_frame_t         frame_info;
    logic [FC_W-1:0]    field_count;
    logic [VALUE_W-1:0] dec_lambda;
    logic [STATUS_W-1:0] dec_status;

    assign is_nul   = (in_char_reg == CH_NUL);
    assign out_free = !out_valid_reg || result.ready;
    assign step     = in_valid_reg && (!is_nul || out_free);
    assign emit     = step && is_nul;

    assign frame.ready = !in_valid_reg || step;

    lfp_field_parser u_parser (
        .clk         (clk),
        .rst_n       (rst_n),
        .step        (step),
        .char_in     (in_char_reg),
        .frame       (frame_info),
        .field_count (field_count)
    );

    lfp_status_decode u_decode (
        .frame        (frame_info),
        .lambda_value (dec_lambda),
        .status       (dec_status)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            in_valid_reg <= 1'b0;
        else if (frame.ready)
            in_valid_reg <= frame.valid;
    end

    always_ff @(posedge clk)
    begin
        if (frame.ready && frame.valid)
            in_char_reg <= frame.char_in;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (out_free)
            out_valid_reg <= emit;
    end

    always_ff @(posedge clk)
    begin
        if (emit)
        begin
            out_lambda_reg <= dec_lambda;
            out_status_reg <= dec_status;
        end
    end

    assign result.valid        = out_valid_reg;
    assign result.lambda_value = out_lambda_reg;
    assign result.status       = out_status_reg;

`ifndef NO_ASSERTIONS
    a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
        field_count <= FC_FULL)
        else $error("field count out of range");

    a_nul_clears: assert property (@(posedge clk) disable iff (!rst_n)
        emit |=> (field_count == '0))
        else $error("frame state not cleared after end of frame");

    a_emit_loads: assert property (@(posedge clk) disable iff (!rst_n)
        emit |=> (result.valid && result.status == $past(dec_status)))
        else $error("result register did not take the decoded status");

    a_lambda_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (result.valid && result.status != ST_OK) |-> (result.lambda_value == '0))
        else $error("lambda value not cleared on error status");
`endif

endmodule

>>> sim/lambda_frame_parser_core_tb.sv
// Self-checking testbench for the lambda frame parser: frame stimulus, status prediction, result check.
`timescale 1ns / 1ps

module lambda_frame_parser_core_tb;

    import lfp_pkg::*;

    localparam int unsigned RANDOM_ITEMS = 1250;
    localparam int unsigned HOLD_CYCLES  = 300;
    localparam int unsigned DRAIN_LIMIT  = 10000;

    typedef struct packed {
        logic [VALUE_W-1:0]  lambda;
        logic [STATUS_W-1:0] status;
    } frame_result_t;

    logic clk = 1'b0;
    logic rst_n;

    lfp_char_if   frame_ch ();
    lfp_result_if result_ch ();

    lambda_frame_parser_core uut (
        .clk    (clk),
        .rst_n  (rst_n),
        .frame  (frame_ch),
        .result (result_ch)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    frame_result_t pending_results[$];
    logic [7:0]    frame_buf[$];
    int unsigned   mismatches     = 0;
    int unsigned   chars_accepted = 0;
    int unsigned   hold_request   = 0;
    int unsigned   burst_left     = 0;
    logic          steady         = 1'b0;
    logic          rx_steady      = 1'b0;

    logic [FC_W-1:0]    fields_done;
    logic [1:0]         phase;
    logic               negative;
    logic [VALUE_W-1:0] magnitude;
    logic [VALUE_W-1:0] lambda_word;
    logic [VALUE_W-1:0] status_word;
    logic [VALUE_W-1:0] probe_word;

    function automatic logic [VALUE_W-1:0] frame_check(input logic [VALUE_W-1:0] l,
                                                       input logic [VALUE_W-1:0] s,
                                                       input logic [VALUE_W-1:0] p);
        return ~VALUE_W'(l + s + p);
    endfunction

    function automatic logic [VALUE_W-1:0] field_value();
        return negative ? VALUE_W'(16'd0 - magnitude) : magnitude;
    endfunction

    function automatic logic [STATUS_W-1:0] decode_status(input logic [VALUE_W-1:0] chk);
        if (frame_check(lambda_word, status_word, probe_word) != chk)
            return ST_CHECKSUM;
        if (probe_word == PROBE_NONE)
            return ST_NO_PROBE;
        if (status_word[0])
            return ST_CJ;
        if (status_word[2])
            return ST_VLOW;
        if (status_word[3])
            return ST_VHIGH;
        if (status_word[4])
            return ST_CJ_COMM;
        if (!status_word[5])
            return status_word[7] ? ST_HEATING : ST_HEAT_OFF;
        if (status_word[1])
            return ST_TEMP_HIGH;
        return ST_OK;
    endfunction

    task automatic clear_number();
        phase     = PH_START;
        negative  = 1'b0;
        magnitude = '0;
    endtask

    task automatic clear_frame();
        fields_done = '0;
        clear_number();
        lambda_word = '0;
        status_word = '0;
        probe_word  = '0;
    endtask

    task automatic track_char(input logic [7:0] c);
        logic [VALUE_W-1:0]  v;
        logic [VALUE_W-1:0]  chk;
        logic                have_last;
        logic [STATUS_W-1:0] st;
        frame_result_t       r;
        if (c == CH_NUL)
        begin
            have_last = 1'b0;
            chk       = '0;
            if (fields_done >= FC_FULL)
            begin
                have_last = 1'b1;
                chk       = magnitude;
            end
            else if (fields_done == FC_LAST && phase != PH_START)
            begin
                have_last = 1'b1;
                chk       = field_value();
            end
            st       = have_last ? decode_status(chk) : ST_CHECKSUM;
            r.lambda = (st == ST_OK) ? lambda_word : '0;
            r.status = st;
            pending_results.push_back(r);
            clear_frame();
        end
        else if (fields_done < FC_FULL)
        begin
            if (c == CH_SEMI)
            begin
                v = field_value();
                case (fields_done)
                    3'd0: lambda_word = v;
                    3'd1: status_word = v;
                    3'd2: probe_word  = v;
                    default: ;
                endcase
                clear_number();
                fields_done = fields_done + 1'b1;
                if (fields_done == FC_FULL)
                    magnitude = v;
            end
            else if (phase == PH_START || phase == PH_SPACE)
            begin
                if (c == CH_SPACE || (c >= CH_TAB && c <= CH_CR))
                    phase = PH_SPACE;
                else if (c == CH_PLUS || c == CH_MINUS)
                begin
                    negative = (c == CH_MINUS);
                    phase    = PH_NUMBER;
                end
                else if (c >= CH_ZERO && c <= CH_NINE)
                begin
                    magnitude = VALUE_W'(c - CH_ZERO);
                    phase     = PH_NUMBER;
                end
                else
                    phase = PH_DONE;
            end
            else if (phase == PH_NUMBER)
            begin
                if (c >= CH_ZERO && c <= CH_NINE)
                    magnitude = magnitude * 16'd10 + VALUE_W'(c - CH_ZERO);
                else
                    phase = PH_DONE;
            end
        end
    endtask

    always @(posedge clk)
    begin
        if (!rst_n)
            clear_frame();
        else if (frame_ch.valid && frame_ch.ready)
        begin
            track_char(frame_ch.char_in);
            chars_accepted++;
        end
    end

    always @(posedge clk)
    begin : check_results
        frame_result_t want;
        if (rst_n && result_ch.valid && result_ch.ready)
        begin
            if (pending_results.size() == 0)
            begin
                $display("%0t: unexpected result, expected none, actual lambda_value=%0d status=%0d",
                         $time, result_ch.lambda_value, result_ch.status);
                mismatches++;
            end
            else
            begin
                want = pending_results.pop_front();
                if (result_ch.lambda_value !== want.lambda)
                begin
                    $display("%0t: lambda_value mismatch, expected %0d, actual %0d",
                             $time, want.lambda, result_ch.lambda_value);
                    mismatches++;
                end
                if (result_ch.status !== want.status)
                begin
                    $display("%0t: status mismatch, expected %0d, actual %0d",
                             $time, want.status, result_ch.status);
                    mismatches++;
                end
            end
        end
    end

    initial
    begin
        int unsigned mode;
        int unsigned mode_left;
        int unsigned hold_left;
        int unsigned tick;
        result_ch.ready = 1'b0;
        mode      = 0;
        mode_left = 0;
        hold_left = 0;
        tick      = 0;
        @(posedge rst_n);
        forever
        begin
            @(negedge clk);
            tick++;
            if (hold_request != 0)
            begin
                hold_left    = hold_request;
                hold_request = 0;
            end
            if (mode_left == 0)
            begin
                mode      = $urandom_range(0, 3);
                mode_left = $urandom_range(20, 200);
            end
            else
                mode_left--;
            if (hold_left != 0)
            begin
                result_ch.ready = 1'b0;
                hold_left--;
            end
            else if (rx_steady || mode == 0)
                result_ch.ready = 1'b1;
            else if (mode == 1)
                result_ch.ready = ($urandom_range(0, 2) != 0);
            else if (mode == 2)
                result_ch.ready = ((tick % 5) >= 2);
            else
                result_ch.ready = ($urandom_range(0, 3) == 0);
        end
    end

    task automatic send_char(input logic [7:0] c);
        frame_ch.char_in = c;
        frame_ch.valid   = 1'b1;
        @(posedge clk);
        while (!frame_ch.ready)
            @(posedge clk);
        @(negedge clk);
        if (!steady)
        begin
            if (burst_left == 0)
            begin
                frame_ch.valid = 1'b0;
                repeat ($urandom_range(1, 6)) @(negedge clk);
                burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(40, 120)
                                                         : $urandom_range(1, 16);
            end
            else
                burst_left--;
        end
    endtask

    task automatic put_char(input logic [7:0] c);
        frame_buf.push_back(c);
    endtask

    task automatic put_text(input string s);
        for (int i = 0; i < s.len(); i++)
            frame_buf.push_back(s[i]);
    endtask

    task automatic put_frame(input logic [VALUE_W-1:0] l, input logic [VALUE_W-1:0] s,
                             input logic [VALUE_W-1:0] p, input logic [VALUE_W-1:0] c);
        put_text($sformatf("%0d;%0d;%0d;%0d", l, s, p, c));
    endtask

    task automatic end_frame();
        frame_buf.push_back(CH_NUL);
        foreach (frame_buf[i])
            send_char(frame_buf[i]);
        frame_buf.delete();
    endtask

    task automatic put_field(input logic [VALUE_W-1:0] v);
        int unsigned form;
        int unsigned pick;
        repeat (($urandom_range(0, 3) == 0) ? $urandom_range(1, 2) : 0)
        begin
            pick = $urandom_range(0, 5);
            put_char((pick == 5) ? CH_SPACE : 8'(CH_TAB + pick));
        end
        form = $urandom_range(0, 5);
        case (form)
            2: put_text($sformatf("+%0d", v));
            3: put_text($sformatf("-%0d", 65536 - int'(v)));
            4: put_text($sformatf("%0d", int'(v) + 65536 * $urandom_range(1, 9999)));
            5: put_text($sformatf("00%0d", v));
            default: put_text($sformatf("%0d", v));
        endcase
        if ($urandom_range(0, 7) == 0)
            repeat ($urandom_range(1, 3))
                put_char(($urandom_range(0, 3) == 0) ? CH_SPACE : 8'($urandom_range(65, 90)));
    endtask

    function automatic logic [VALUE_W-1:0] random_status_word();
        case ($urandom_range(0, 4))
            0: return VALUE_W'($urandom);
            1: return 16'h0020 | (16'h0002 & VALUE_W'($urandom));
            2: return 16'h0020 | VALUE_W'(1 << $urandom_range(0, 4));
            3: return VALUE_W'($urandom) & ~16'h003D;
            default: return 16'h0020 | (VALUE_W'($urandom) & 16'hFF40);
        endcase
    endfunction

    task automatic test_status_codes();
        logic [VALUE_W-1:0] status_words [8];
        status_words = '{16'h0021, 16'h0024, 16'h0028, 16'h0030, 16'h0000, 16'h0080,
                         16'h0022, 16'hFFFF};
        put_frame(16'd1000, 16'h0020, 16'd500, frame_check(16'd1000, 16'h0020, 16'd500));
        end_frame();
        put_frame(16'hFFFF, 16'h0020, 16'hFFFF, frame_check(16'hFFFF, 16'h0020, 16'hFFFF));
        end_frame();
        put_frame(16'd0, 16'h0020, 16'd0, frame_check(16'd0, 16'h0020, 16'd0));
        end_frame();
        put_frame(16'd1000, 16'h0020, 16'd500, frame_check(16'd1000, 16'h0020, 16'd500) ^ 16'd1);
        end_frame();
        put_frame(16'd900, 16'h0020, PROBE_NONE, frame_check(16'd900, 16'h0020, PROBE_NONE));
        end_frame();
        foreach (status_words[i])
        begin
            put_frame(16'd700, status_words[i], 16'd300,
                      frame_check(16'd700, status_words[i], 16'd300));
            end_frame();
        end
    endtask

    task automatic test_short_frames();
        end_frame();
        put_text("5;32");
        end_frame();
        put_text("1;2;3");
        end_frame();
        put_text("1;2;3;");
        end_frame();
        put_text("65535;32;65504; ");
        end_frame();
        put_text("65535;32;65504;-");
        end_frame();
    endtask

    task automatic test_number_forms();
        for (int i = 0; i < 5; i++)
            put_char(8'(CH_TAB + i));
        put_char(CH_SPACE);
        put_text("1000;  +32abc;00500xyz;");
        put_text($sformatf("-%0d", 65536 - int'(frame_check(16'd1000, 16'h0020, 16'd500))));
        end_frame();
        put_text($sformatf("70000;65568;-1;%0d", frame_check(16'd4464, 16'h0020, 16'hFFFF)));
        end_frame();
        put_char(8'hFF);
        put_text("123;");
        put_char(8'h01);
        put_text("32;");
        put_char(8'h80);
        put_text("5;7");
        end_frame();
        put_text("+-5;- 5;+;-0");
        end_frame();
    endtask

    task automatic test_extra_text();
        put_frame(16'd1234, 16'h0020, 16'd77, frame_check(16'd1234, 16'h0020, 16'd77));
        put_text(";;junk;12");
        put_char(8'hFF);
        end_frame();
        put_frame(16'd42, 16'h0022, 16'd9, frame_check(16'd42, 16'h0022, 16'd9));
        put_text("; 99");
        end_frame();
    endtask

    task automatic test_backpressure();
        logic [VALUE_W-1:0] l;
        hold_request = HOLD_CYCLES;
        steady       = 1'b1;
        repeat (12)
        begin
            l = VALUE_W'($urandom);
            put_frame(l, 16'h0020, 16'd400, frame_check(l, 16'h0020, 16'd400));
            end_frame();
        end
        steady = 1'b0;
    endtask

    task automatic test_random_frames();
        logic [VALUE_W-1:0] l;
        logic [VALUE_W-1:0] s;
        logic [VALUE_W-1:0] p;
        logic [VALUE_W-1:0] c;
        int unsigned        kind;
        int unsigned        cut;
        int unsigned        start;
        start = chars_accepted;
        while (chars_accepted - start < RANDOM_ITEMS)
        begin
            kind = $urandom_range(0, 99);
            if (kind < 15)
            begin
                repeat ($urandom_range(0, 20))
                    put_char(($urandom_range(0, 4) == 0) ? CH_SEMI : 8'($urandom_range(1, 255)));
            end
            else
            begin
                l = VALUE_W'($urandom);
                s = random_status_word();
                p = ($urandom_range(0, 9) == 0) ? PROBE_NONE : VALUE_W'($urandom);
                c = frame_check(l, s, p);
                if ($urandom_range(0, 6) == 0)
                    c ^= VALUE_W'(1 << $urandom_range(0, 15));
                put_field(l);
                put_char(CH_SEMI);
                put_field(s);
                put_char(CH_SEMI);
                put_field(p);
                put_char(CH_SEMI);
                put_field(c);
                if ($urandom_range(0, 4) == 0)
                begin
                    put_char(CH_SEMI);
                    repeat ($urandom_range(0, 8))
                        put_char(8'($urandom_range(1, 255)));
                end
                if (kind >= 85)
                begin
                    cut = $urandom_range(0, frame_buf.size() - 1);
                    while (frame_buf.size() > cut)
                        void'(frame_buf.pop_back());
                end
            end
            end_frame();
        end
    endtask

    initial
    begin
        int unsigned drain;
        rst_n            = 1'b0;
        frame_ch.valid   = 1'b0;
        frame_ch.char_in = CH_NUL;
        repeat (6) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        test_status_codes();
        test_short_frames();
        test_number_forms();
        test_extra_text();
        test_backpressure();
        test_random_frames();

        frame_ch.valid = 1'b0;
        rx_steady      = 1'b1;
        drain          = 0;
        while (pending_results.size() != 0 && drain < DRAIN_LIMIT)
        begin
            @(posedge clk);
            drain++;
        end
        repeat (10) @(posedge clk);
        if (pending_results.size() != 0)
        begin
            $display("%0t: %0d results expected but never received", $time,
                     pending_results.size());
            mismatches += pending_results.size();
        end
        if (mismatches == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

    initial
    begin
        #3000000;
        $display("FAIL");
        $finish;
    end

endmodule
